// File: design/pdl_pkg.sv
// Package for the percent decoder with LDAP stop rule.
// Holds the result record, status codes and character constants; no dependencies.
package pdl_pkg;

	localparam int ByteW = 8;
	localparam int StatusW = 2;
	localparam int QCountW = 3;

	localparam logic [StatusW-1:0] ST_RUNNING = 2'd0;
	localparam logic [StatusW-1:0] ST_DONE_OK = 2'd1;
	localparam logic [StatusW-1:0] ST_BAD_ESC = 2'd2;

	localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
	localparam logic [ByteW-1:0] CH_QMARK = 8'h3f;
	localparam logic [ByteW-1:0] CH_ZERO = 8'h30;
	localparam logic [ByteW-1:0] CH_NINE = 8'h39;
	localparam logic [ByteW-1:0] CH_UP_A = 8'h41;
	localparam logic [ByteW-1:0] CH_UP_F = 8'h46;
	localparam logic [ByteW-1:0] CASE_MASK = 8'hdf;

	localparam logic [QCountW-1:0] QMARK_LIMIT = 3'd4;

	// One result as it leaves the decode logic.
	typedef struct packed {
		logic valid;
		logic [ByteW-1:0] out_byte;
		logic has_byte;
		logic [StatusW-1:0] status;
		logic is_last;
	} result_t;

endpackage

// File: design/pdl_core.sv
// Decode logic and per-string state of the percent decoder.
// Depends on pdl_pkg for the result record and constants.
module pdl_core (
	input  logic clk,
	input  logic arst_n,
	input  logic ldap_mode,
	input  logic item_valid,
	input  logic [pdl_pkg::ByteW-1:0] item_byte,
	input  logic item_last,
	input  logic advance,
	output pdl_pkg::result_t result
);

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_HEX1  = 2'd1,
		PH_HEX2  = 2'd2,
		PH_DRAIN = 2'd3
	} phase_t;

	phase_t phase_q, phase_nxt;
	logic [3:0] nibble_q, nibble_nxt;
	logic [pdl_pkg::QCountW-1:0] qcount_q, qcount_nxt;
	logic stopped_q, stopped_nxt;

	logic [pdl_pkg::ByteW-1:0] upper;
	logic is_hex;
	logic [3:0] hex_val;
	logic do_data, do_err, do_clear;
	logic [pdl_pkg::ByteW-1:0] data_val;
	logic [pdl_pkg::QCountW-1:0] qcount_inc;

	always_comb begin
		upper = item_byte & pdl_pkg::CASE_MASK;
		if (item_byte >= pdl_pkg::CH_ZERO && item_byte <= pdl_pkg::CH_NINE) begin
			is_hex = 1'b1;
			hex_val = item_byte[3:0];
		end else if (upper >= pdl_pkg::CH_UP_A && upper <= pdl_pkg::CH_UP_F) begin
			is_hex = 1'b1;
			hex_val = upper[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
			hex_val = 4'd0;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		nibble_nxt = nibble_q;
		do_data = 1'b0;
		do_err = 1'b0;
		do_clear = 1'b0;
		data_val = item_byte;
		unique case (phase_q)
			PH_PLAIN: begin
				if (!stopped_q && item_byte == pdl_pkg::CH_PERCENT) begin
					if (item_last) begin
						do_err = 1'b1;
					end else begin
						phase_nxt = PH_HEX1;
					end
				end else begin
					do_data = 1'b1;
				end
			end
			PH_HEX1: begin
				if (!is_hex || item_last) begin
					do_err = 1'b1;
				end else begin
					nibble_nxt = hex_val;
					phase_nxt = PH_HEX2;
				end
			end
			PH_HEX2: begin
				if (!is_hex) begin
					do_err = 1'b1;
				end else begin
					phase_nxt = PH_PLAIN;
					do_data = 1'b1;
					data_val = {nibble_q, hex_val};
				end
			end
			PH_DRAIN: begin
				do_clear = item_last;
			end
			default: begin
				phase_nxt = PH_PLAIN;
			end
		endcase

		// A bad escape in mid-string discards bytes until the string ends.
		if (do_err && !item_last) begin
			phase_nxt = PH_DRAIN;
		end
		if ((do_err || do_data) && item_last) begin
			do_clear = 1'b1;
		end

		qcount_nxt = qcount_q;
		stopped_nxt = stopped_q;
		qcount_inc = (qcount_q < pdl_pkg::QMARK_LIMIT) ? qcount_q + 3'd1 : qcount_q;
		if (do_data && ldap_mode && data_val == pdl_pkg::CH_QMARK) begin
			qcount_nxt = qcount_inc;
			if (qcount_inc >= pdl_pkg::QMARK_LIMIT) begin
				stopped_nxt = 1'b1;
			end
		end

		if (do_clear) begin
			phase_nxt = PH_PLAIN;
			nibble_nxt = 4'd0;
			qcount_nxt = '0;
			stopped_nxt = 1'b0;
		end

		result.valid = item_valid && (do_data || do_err);
		result.out_byte = do_data ? data_val : '0;
		result.has_byte = do_data;
		result.status = do_err ? pdl_pkg::ST_BAD_ESC :
			(item_last ? pdl_pkg::ST_DONE_OK : pdl_pkg::ST_RUNNING);
		result.is_last = do_err || item_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			nibble_q <= 4'd0;
			qcount_q <= '0;
			stopped_q <= 1'b0;
		end else if (item_valid && advance) begin
			phase_q <= phase_nxt;
			nibble_q <= nibble_nxt;
			qcount_q <= qcount_nxt;
			stopped_q <= stopped_nxt;
		end
	end

endmodule

// File: design/pdl_out_reg.sv
// Result register of the percent decoder, the output stage of the pipeline.
// Depends on pdl_pkg for the result record.
module pdl_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  pdl_pkg::result_t result,
	input  logic load,
	input  logic out_stall,
	output logic free,
	output logic out_valid,
	output logic [pdl_pkg::ByteW-1:0] out_byte,
	output logic has_byte,
	output logic [pdl_pkg::StatusW-1:0] status,
	output logic is_last
);

	logic valid_s2;
	pdl_pkg::result_t res_s2;

	assign free = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_byte = res_s2.out_byte;
	assign has_byte = res_s2.has_byte;
	assign status = res_s2.status;
	assign is_last = res_s2.is_last;

endmodule

// File: design/percent_decoder_ldap_stop.sv
// Top level of the streaming URL percent decoder with LDAP stop rule.
// Depends on pdl_pkg, pdl_core and pdl_out_reg.
//
// The input channel carries one byte of an escaped string per transfer, with
// in_last marking the final byte. A transfer happens at a rising edge where
// in_valid is high and in_stall is low; the output channel works the same way
// with out_valid and out_stall. Each input transfer gives zero or one result:
// an escape start or an escape digit gives none, a decoded or plain byte gives
// a data result, and a bad or truncated escape gives one error result that
// ends the string, after which bytes are dropped up to the next in_last.
// The block takes one byte every cycle while in_stall is low. A byte lands
// in an input register, the decode logic acts on it there, and as it moves
// on, the per-string state updates and its result is loaded into the output
// register. When the receiver stalls with a result held, the input register
// keeps its byte and in_stall rises only if that byte would produce another
// result; bytes that give no result still move on. With out_stall low,
// in_stall is never high. Reset clears the string state, both stage valid
// bits and ldap_mode. The user writes ldap_mode through cfg_wr_en and
// cfg_wr_data only while idle; the block itself has no check for this.
module percent_decoder_ldap_stop (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [pdl_pkg::ByteW-1:0] in_byte,
	input  logic in_last,
	output logic out_valid,
	input  logic out_stall,
	output logic [pdl_pkg::ByteW-1:0] out_byte,
	output logic has_byte,
	output logic [pdl_pkg::StatusW-1:0] status,
	output logic is_last
);

	logic ldap_mode_q;
	logic valid_s1;
	logic [pdl_pkg::ByteW-1:0] byte_s1;
	logic last_s1;
	logic advance;
	logic out_free;
	pdl_pkg::result_t result;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ldap_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ldap_mode_q <= cfg_wr_data;
		end
	end

	// The held byte moves on unless its result has nowhere to go.
	assign advance = !result.valid || out_free;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	pdl_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ldap_mode  (ldap_mode_q),
		.item_valid (valid_s1),
		.item_byte  (byte_s1),
		.item_last  (last_s1),
		.advance    (advance),
		.result     (result)
	);

	pdl_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.load      (valid_s1),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.status    (status),
		.is_last   (is_last)
	);

	// An error result never carries a data byte and always ends the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pdl_pkg::ST_BAD_ESC |-> !has_byte && is_last)
	else $error("error result carries data or does not end the string");

	// Only the end of a string reports a finished status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_last == (status != pdl_pkg::ST_RUNNING)))
	else $error("is_last and status disagree");

	// Back-pressure on the input only ever comes from a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
	else $error("input stalled while output is free");

	// A stall always holds a byte in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && result.valid)
	else $error("input stalled without a pending result");

endmodule

// File: dv/pdl_decode_check_pkg.sv
// Scoreboard for the percent decoder testbench: a bit-level predictor of the
// decoder and the queue of decoded results it is waiting for. Depends on pdl_pkg.
`timescale 1ns / 1ps
package pdl_decode_check_pkg;

	import pdl_pkg::*;

	typedef enum logic [1:0] {SCAN_PLAIN, SCAN_PCT, SCAN_DIGIT, SCAN_SKIP} scan_t;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic has;
		logic [StatusW-1:0] st;
		logic last;
	} decoded_t;

	// Returns 1 and the nibble value if c is a hex digit in either case.
	function automatic bit hex_nibble(input logic [ByteW-1:0] c, output logic [3:0] v);
		logic [ByteW-1:0] up;
		logic [ByteW-1:0] tmp;
		up = c & CASE_MASK;
		v = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			tmp = c - CH_ZERO;
			v = tmp[3:0];
			return 1'b1;
		end
		if (up >= CH_UP_A && up <= CH_UP_F) begin
			tmp = up - CH_UP_A + 8'd10;
			v = tmp[3:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	class escape_scoreboard;
		bit ldap_on;
		scan_t scan;
		logic [3:0] hi_nib;
		logic [QCountW-1:0] q_seen;
		bit stopped;
		decoded_t due[$];
		int unsigned items;
		int unsigned results;
		int unsigned bad_endings;
		int unsigned stops;
		int unsigned failures;

		function new();
			ldap_on = 1'b0;
			items = 0;
			results = 0;
			bad_endings = 0;
			stops = 0;
			failures = 0;
			clear_string();
		endfunction

		function void set_ldap_mode(bit m);
			ldap_on = m;
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction

		function void clear_string();
			scan = SCAN_PLAIN;
			hi_nib = '0;
			q_seen = '0;
			stopped = 1'b0;
		endfunction

		function void emit_data(logic [ByteW-1:0] b, bit last);
			decoded_t r;
			if (ldap_on && b == CH_QMARK) begin
				if (q_seen < QMARK_LIMIT)
					q_seen++;
				if (q_seen >= QMARK_LIMIT && !stopped) begin
					stopped = 1'b1;
					stops++;
				end
			end
			r.data = b;
			r.has = 1'b1;
			r.st = last ? ST_DONE_OK : ST_RUNNING;
			r.last = last;
			due.push_back(r);
			if (last)
				clear_string();
		endfunction

		function void emit_error(bit last);
			decoded_t r;
			r.data = '0;
			r.has = 1'b0;
			r.st = ST_BAD_ESC;
			r.last = 1'b1;
			due.push_back(r);
			bad_endings++;
			if (last)
				clear_string();
			else
				scan = SCAN_SKIP;
		endfunction

		// Called for every accepted input transfer.
		function void take_byte(logic [ByteW-1:0] b, bit last);
			logic [3:0] v;
			items++;
			case (scan)
				SCAN_PLAIN: begin
					if (!stopped && b == CH_PERCENT) begin
						if (last)
							emit_error(last);
						else
							scan = SCAN_PCT;
					end else begin
						emit_data(b, last);
					end
				end
				SCAN_PCT: begin
					if (!hex_nibble(b, v) || last) begin
						emit_error(last);
					end else begin
						hi_nib = v;
						scan = SCAN_DIGIT;
					end
				end
				SCAN_DIGIT: begin
					if (!hex_nibble(b, v)) begin
						emit_error(last);
					end else begin
						scan = SCAN_PLAIN;
						emit_data({hi_nib, v}, last);
					end
				end
				default: begin
					if (last)
						clear_string();
				end
			endcase
		endfunction

		function void note_failure(string what, decoded_t exp, decoded_t got);
			failures++;
			if (failures <= 10)
				$display("%0t MISMATCH %s: exp byte=%02h has=%0b st=%0d last=%0b, got byte=%02h has=%0b st=%0d last=%0b",
					$time, what, exp.data, exp.has, exp.st, exp.last,
					got.data, got.has, got.st, got.last);
		endfunction

		// Called for every accepted result transfer.
		function void check_result(logic [ByteW-1:0] b, logic has, logic [StatusW-1:0] st,
				logic last);
			decoded_t got;
			decoded_t exp;
			got.data = b;
			got.has = has;
			got.st = st;
			got.last = last;
			results++;
			if (due.size() == 0) begin
				note_failure("unexpected result", '0, got);
				return;
			end
			exp = due.pop_front();
			if (got.data !== exp.data || got.has !== exp.has || got.st !== exp.st ||
					got.last !== exp.last)
				note_failure("field", exp, got);
		endfunction

		function void flush_check();
			decoded_t exp;
			while (due.size() > 0) begin
				exp = due.pop_front();
				note_failure("missing result", exp, '0);
			end
		endfunction
	endclass

endpackage

// File: dv/testbench.sv
// Top-level testbench for percent_decoder_ldap_stop: directed and random byte
// strings with random idling on both channels. Depends on pdl_pkg and pdl_decode_check_pkg.
`timescale 1ns / 1ps
module testbench;

	import pdl_pkg::*;
	import pdl_decode_check_pkg::*;

	// If nothing moves on either channel for this many cycles, the run is hung.
	localparam int QUIET_LIMIT = 2000;
	// Length of the one long receiver hold-off.
	localparam int HOLD_CYCLES = 48;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [ByteW-1:0] in_byte;
	logic in_last;
	logic out_valid;
	logic out_stall;
	logic [ByteW-1:0] out_byte;
	logic has_byte;
	logic [StatusW-1:0] status;
	logic is_last;

	// Idle percentages for the current phase, and the hold-off handshake
	// between the main sequence and the receiver process.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit pressure_go = 1'b0;
	bit pressure_done = 1'b0;
	int unsigned input_stalls = 0;

	escape_scoreboard sb;

	percent_decoder_ldap_stop dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.status(status),
		.is_last(is_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hex digit for a nibble; letters come out in a random case.
	function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n);
		logic [ByteW-1:0] c;
		if (n < 4'd10)
			c = CH_ZERO + ByteW'(n);
		else
			c = CH_UP_A + ByteW'(n) - 8'd10;
		// Setting the case bit leaves digits alone and lowers letters.
		if ($urandom_range(0, 1))
			c = c | ~CASE_MASK;
		return c;
	endfunction

	// A byte that is not a hex digit. Half the time it is one of the
	// neighbors of the digit and letter ranges, which are the likely slips.
	function automatic logic [ByteW-1:0] non_hex_char();
		logic [ByteW-1:0] c;
		logic [3:0] v;
		case ($urandom_range(0, 11))
			0: c = CH_ZERO - 8'd1;
			1: c = CH_NINE + 8'd1;
			2: c = CH_UP_A - 8'd1;
			3: c = CH_UP_F + 8'd1;
			4: c = (CH_UP_A | ~CASE_MASK) - 8'd1;
			5: c = (CH_UP_F | ~CASE_MASK) + 8'd1;
			default: begin
				c = CH_ZERO;
				while (hex_nibble(c, v))
					c = ByteW'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	// Offers one byte and returns right after the edge where it was taken.
	// The idle loop only lowers valid in steps where nothing else drives it.
	task automatic send_item(input logic [ByteW-1:0] b, input bit last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_text(input string s, input bit last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], last && (i == s.len() - 1));
	endtask

	// One random string. Most tokens are well formed (plain bytes, question
	// marks, escapes that often encode a question mark) so that strings get
	// deep into the LDAP counting; a few are bad or cut-off escapes.
	task automatic send_random_string(output int unsigned count);
		logic [ByteW-1:0] q[$];
		logic [ByteW-1:0] code;
		int tokens;
		int pick;
		bit cut;
		tokens = $urandom_range(1, 12);
		cut = 1'b0;
		for (int t = 0; t < tokens && !cut; t++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				q.push_back(ByteW'($urandom_range(0, 255)));
			end else if (pick < 65) begin
				q.push_back(CH_QMARK);
			end else if (pick < 90) begin
				code = ($urandom_range(0, 4) == 0) ? CH_QMARK :
					ByteW'($urandom_range(0, 255));
				q.push_back(CH_PERCENT);
				q.push_back(hex_char(code[7:4]));
				q.push_back(hex_char(code[3:0]));
			end else if (pick < 95) begin
				// Bad first or second digit; the rest of the string is dropped.
				q.push_back(CH_PERCENT);
				if ($urandom_range(0, 1))
					q.push_back(hex_char(4'($urandom_range(0, 15))));
				q.push_back(non_hex_char());
			end else begin
				// The string ends inside the escape.
				q.push_back(CH_PERCENT);
				if ($urandom_range(0, 1))
					q.push_back(hex_char(4'($urandom_range(0, 15))));
				cut = 1'b1;
			end
		end
		foreach (q[i])
			send_item(q[i], i == q.size() - 1);
		count = q.size();
	endtask

	task automatic random_run(input int unsigned target);
		int unsigned sent;
		int unsigned n;
		sent = 0;
		while (sent < target) begin
			send_random_string(n);
			sent += n;
		end
	endtask

	// Writes ldap_mode once the block has drained. Escape starts and digits
	// give no result, so it keeps waiting after the queue empties for bytes in flight.
	task automatic write_mode(input bit m);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_ldap_mode(m);
	endtask

	// Receiver: stalls at the phase's rate, and once holds off for a long
	// stretch so that the block fills up and has to stall its input.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_go && !pressure_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Both channels are sampled at the edge where a transfer happens. Inputs
	// are noted before results are checked; a result passes the input and output registers
	// after its input is taken, so the order within the edge does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_byte(in_byte, in_last);
			if (in_valid && in_stall)
				input_stalls++;
			if (out_valid && !out_stall)
				sb.check_result(out_byte, has_byte, status, is_last);
		end
	end

	// Watchdog on cycles in which no transfer happens on either channel.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		in_last <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain decoding. Extremes of the byte range pass through, escapes
		// decode in both cases including a decoded zero, a bad digit ends the
		// string and the rest is dropped up to its last byte, and a string
		// cut off on the percent sign or on the first digit gives an error.
		write_mode(1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_text("%41%ff%00%aB", 1'b1);
		send_text("%Gxy", 1'b1);
		send_text("%", 1'b1);
		send_text("%4", 1'b1);

		// LDAP mode: the decoded question mark counts, and after the fourth
		// one the percent sign and its digits pass through as plain bytes.
		write_mode(1'b1);
		send_text("?%3F??%41", 1'b1);

		// Random strings, sender idling lightly and receiver heavily, then the reverse.
		// Each phase stops inside an escape, so the next mode applies mid-string.
		send_idle_pct = 14;
		recv_idle_pct = 60;
		random_run(600);
		send_item(CH_QMARK, 1'b0);
		send_item(CH_PERCENT, 1'b0);

		write_mode(1'b0);
		send_idle_pct = 60;
		recv_idle_pct = 14;
		random_run(600);
		send_item(CH_QMARK, 1'b0);
		send_item(CH_PERCENT, 1'b0);

		// Full rate on both sides, with the long receiver hold-off partway.
		write_mode(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_run(300);
		pressure_go = 1'b1;
		random_run(300);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		sb.flush_check();

		$display("Run covered %0d input transfers and %0d results in both ldap_mode settings,",
			sb.items, sb.results);
		$display("with %0d bad or cut-off escapes, %0d LDAP decode stops, %0d input stall cycles.",
			sb.bad_endings, sb.stops, input_stalls);
		if (sb.failures == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
